// ===== src/bfgr_pkg.sv =====
// Shared types, codes and helpers for the bitmap font glyph renderer.
`timescale 1ns / 1ps
`default_nettype none

package bfgr_pkg;

    localparam int STORE_DEPTH   = 1024;
    localparam int STORE_AW      = 10;
    localparam int QUEUE_DEPTH   = 4;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [3:0] MAX_WIDTH    = 4'd8;

    typedef enum logic [1:0] {
        REQ_TEXT   = 2'd0,
        REQ_GLYPH  = 2'd1,
        REQ_CURSOR = 2'd2,
        REQ_FONT   = 2'd3
    } t_req;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_FIRST_CODE       = 3'd0,
        CFG_LAST_CODE        = 3'd1,
        CFG_CELL_WIDTH       = 3'd2,
        CFG_SCALE_FACTOR     = 3'd3,
        CFG_GLYPH_GAP        = 3'd4,
        CFG_PAINT_BACKGROUND = 3'd5,
        CFG_FORE_COLOR       = 3'd6,
        CFG_BACK_COLOR       = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] char_code;
        logic       text_start;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [9:0] font_address;
        logic [7:0] font_row;
    } t_in_beat;

    typedef struct packed {
        logic [15:0] cell_x;
        logic [15:0] cell_y;
        logic [31:0] cell_color;
        logic        last_cell;
    } t_out_beat;

    typedef struct packed {
        logic [7:0] first_code;
        logic [7:0] last_code;
        logic [3:0] cell_width;
        logic [3:0] scale_factor;
        logic [3:0] glyph_gap;
        logic       paint_background;
    } t_cfg;

    function automatic logic [3:0] eff_width(input logic [3:0] width);
        return (width > MAX_WIDTH) ? MAX_WIDTH : width;
    endfunction

endpackage

`default_nettype wire

// ===== src/bfgr_front.sv =====
// Front end: accepts beats, tracks the cursor and queues draw and font-load commands.
`timescale 1ns / 1ps
`default_nettype none

module bfgr_front import bfgr_pkg::*; #(
    parameter int FONT_SLOTS = 128,
    parameter int GLYPH_ROWS = 8,
    parameter int COORD_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  t_cfg                                  i_cfg,
    input  logic                                  i_in_valid,
    input  t_in_beat                              i_in_data,
    output logic                                  o_in_stall,
    input  logic                                  i_q_full,
    output logic                                  o_q_push,
    output logic [2*COORD_BITS+STORE_AW+8:0]      o_q_data
);

    logic [COORD_BITS-1:0] r_cur_x, r_cur_y, r_line_x;
    logic [COORD_BITS-1:0] n_cur_x, n_cur_y, n_line_x;
    logic [COORD_BITS-1:0] px, py, line_x;
    logic [COORD_BITS-1:0] cmd_x, cmd_y;
    logic [STORE_AW-1:0]   cmd_addr, base;
    logic                  cmd_font;
    logic                  accept, present, scale_on;
    logic [3:0]            width;
    logic [7:0]            slot;
    logic [17:0]           slot_prod;
    logic [4:0]            wg, rg;
    logic [8:0]            adv, lf_adv;

    always_comb begin
        accept    = i_in_valid && !i_q_full;
        scale_on  = (i_cfg.scale_factor != 4'd0);
        width     = eff_width(i_cfg.cell_width);
        slot      = i_in_data.char_code - i_cfg.first_code;
        present   = (i_in_data.char_code >= i_cfg.first_code)
                 && (i_in_data.char_code <= i_cfg.last_code)
                 && ({1'b0, slot} < 9'(FONT_SLOTS));
        slot_prod = 18'(slot) * 18'(GLYPH_ROWS);
        base      = slot_prod[STORE_AW-1:0];
        wg        = {1'b0, width} + {1'b0, i_cfg.glyph_gap};
        rg        = 5'(GLYPH_ROWS) + {1'b0, i_cfg.glyph_gap};
        adv       = 9'(wg) * 9'(i_cfg.scale_factor);
        lf_adv    = 9'(rg) * 9'(i_cfg.scale_factor);
        px        = COORD_BITS'(i_in_data.pos_x);
        py        = COORD_BITS'(i_in_data.pos_y);
        line_x    = i_in_data.text_start ? r_cur_x : r_line_x;

        n_cur_x   = r_cur_x;
        n_cur_y   = r_cur_y;
        n_line_x  = r_line_x;
        o_q_push  = 1'b0;
        cmd_font  = 1'b0;
        cmd_x     = r_cur_x;
        cmd_y     = r_cur_y;
        cmd_addr  = base;

        if (accept) begin
            case (i_in_data.req_type)
                REQ_TEXT: begin
                    if (scale_on) begin
                        n_line_x = line_x;
                        if (i_in_data.char_code == NEWLINE_CODE) begin
                            n_cur_x = line_x;
                            n_cur_y = r_cur_y + COORD_BITS'(lf_adv);
                        end else if (present) begin
                            o_q_push = 1'b1;
                            n_cur_x  = r_cur_x + COORD_BITS'(adv);
                        end
                    end
                end
                REQ_GLYPH: begin
                    if (scale_on && present) begin
                        o_q_push = 1'b1;
                        cmd_x    = px;
                        cmd_y    = py;
                        n_cur_x  = px + COORD_BITS'(adv);
                        n_cur_y  = py;
                    end
                end
                REQ_CURSOR: begin
                    n_cur_x = px;
                    n_cur_y = py;
                end
                REQ_FONT: begin
                    o_q_push = 1'b1;
                    cmd_font = 1'b1;
                    cmd_addr = i_in_data.font_address;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall = i_q_full;
    assign o_q_data   = {cmd_font, cmd_x, cmd_y, cmd_addr, i_in_data.font_row};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x  <= '0;
            r_cur_y  <= '0;
            r_line_x <= '0;
        end else begin
            r_cur_x  <= n_cur_x;
            r_cur_y  <= n_cur_y;
            r_line_x <= n_line_x;
        end
    end

endmodule

`default_nettype wire

// ===== src/bfgr_queue.sv =====
// Short command queue between the front end and the drawing engine.
`timescale 1ns / 1ps
`default_nettype none

module bfgr_queue import bfgr_pkg::*; #(
    parameter int WIDTH = 51
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int QPW = $clog2(QUEUE_DEPTH);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [QPW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QPW:0]     r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == (QPW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== src/bfgr_back.sv =====
// Drawing engine: holds the font store, fetches glyph rows and emits scaled cells.
`timescale 1ns / 1ps
`default_nettype none

module bfgr_back import bfgr_pkg::*; #(
    parameter int GLYPH_ROWS = 8,
    parameter int COORD_BITS = 16,
    parameter int COLOR_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  t_cfg                              i_cfg,
    input  logic [COLOR_BITS-1:0]             i_fore_color,
    input  logic [COLOR_BITS-1:0]             i_back_color,
    input  logic                              i_q_valid,
    input  logic [2*COORD_BITS+STORE_AW+8:0]  i_q_data,
    output logic                              o_q_pop,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output t_out_beat                         o_out_data
);

    localparam int CMD_BITS = 2*COORD_BITS + STORE_AW + 9;
    localparam int NP       = GLYPH_ROWS * 8;
    localparam int PW       = $clog2(NP);
    localparam int RCW      = $clog2(GLYPH_ROWS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_DRAW
    } t_state;

    t_state                r_state;
    logic [RCW-1:0]        r_cnt;
    logic [PW-1:0]         r_pix;
    logic [STORE_AW-1:0]   r_base;
    logic [COORD_BITS-1:0] r_org_x, r_org_y;
    logic [7:0]            r_rows [GLYPH_ROWS];
    logic [7:0]            r_rd_data;
    logic [7:0]            r_store [STORE_DEPTH];
    logic                  r_out_valid;
    t_out_beat             r_out;

    logic                  q_font;
    logic [COORD_BITS-1:0] q_x, q_y;
    logic [STORE_AW-1:0]   q_addr, rd_addr;
    logic [7:0]            q_row;
    logic                  store_we;
    logic [3:0]            width;
    logic [3:0]            sel;
    logic [NP-1:0]         em, lit_v, rest;
    logic                  later, cur_em, cur_lit, can_emit, step;
    logic [2:0]            gx;
    logic [PW-1:0]         gy;
    logic [6:0]            xoff;
    logic [PW+3:0]         yoff;
    logic [COORD_BITS-1:0] cell_x, cell_y;
    logic [COLOR_BITS-1:0] color;

    always_comb begin
        q_font = i_q_data[CMD_BITS-1];
        q_x    = i_q_data[STORE_AW+8+COORD_BITS +: COORD_BITS];
        q_y    = i_q_data[STORE_AW+8 +: COORD_BITS];
        q_addr = i_q_data[8 +: STORE_AW];
        q_row  = i_q_data[7:0];
        width  = eff_width(i_cfg.cell_width);
        sel    = '0;
        for (int k = 0; k < NP; k++) begin
            sel      = width - 4'(k % 8) - 4'd1;
            lit_v[k] = r_rows[k / 8][sel[2:0]];
            em[k]    = (4'(k % 8) < width) && (lit_v[k] || i_cfg.paint_background);
        end
        rest     = (em >> r_pix) >> 1;
        later    = |rest;
        cur_em   = em[r_pix];
        cur_lit  = lit_v[r_pix];
        can_emit = !r_out_valid || !i_out_stall;
        step     = !cur_em || can_emit;
        gx       = r_pix[2:0];
        gy       = r_pix >> 3;
        xoff     = {4'b0, gx} * {3'b0, i_cfg.scale_factor};
        yoff     = (PW+4)'(gy) * (PW+4)'(i_cfg.scale_factor);
        cell_x   = r_org_x + COORD_BITS'(xoff);
        cell_y   = r_org_y + COORD_BITS'(yoff);
        color    = cur_lit ? i_fore_color : i_back_color;
        rd_addr  = r_base + STORE_AW'(r_cnt);
        o_q_pop  = (r_state == S_IDLE) && i_q_valid;
        store_we = o_q_pop && q_font;
    end

    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[q_addr] <= q_row;
        end
        r_rd_data <= r_store[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_pix       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_DRAW) && cur_em && can_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid && !q_font) begin
                        r_base  <= q_addr;
                        r_org_x <= q_x;
                        r_org_y <= q_y;
                        r_cnt   <= '0;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    if (r_cnt != '0) begin
                        for (int i = 0; i < GLYPH_ROWS - 1; i++) begin
                            r_rows[i] <= r_rows[i+1];
                        end
                        r_rows[GLYPH_ROWS-1] <= r_rd_data;
                    end
                    if (r_cnt == RCW'(GLYPH_ROWS)) begin
                        r_pix   <= '0;
                        r_state <= S_DRAW;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DRAW: begin
                    if (cur_em && can_emit) begin
                        r_out.cell_x     <= 16'(cell_x);
                        r_out.cell_y     <= 16'(cell_y);
                        r_out.cell_color <= 32'(color);
                        r_out.last_cell  <= !later;
                    end
                    if (step) begin
                        if (!later) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_pix <= r_pix + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ===== src/bitmap_font_glyph_renderer.sv =====
// Top level of the bitmap font glyph renderer: configuration registers and block wiring.
`timescale 1ns / 1ps
`default_nettype none

// Text, glyph, cursor and font-load beats enter a front end that takes one beat per cycle
// while the queue is not full, updates the cursor at once and queues draw and font-load
// commands (four deep). The drawing engine takes one command per cycle from the queue
// while it is idle; a font load finishes in that cycle. A drawn glyph then fetches its rows
// from the 1024 x 8 font store (one read port), then steps through each pixel position,
// left to right and row by row, up to its last emitted cell: at most GLYPH_ROWS * 8 cells,
// one per cycle while the output is not stalled. The font store is not cleared after
// reset; glyph rows must be loaded before they are drawn.

module bitmap_font_glyph_renderer import bfgr_pkg::*; #(
    parameter int FONT_SLOTS = 128,
    parameter int GLYPH_ROWS = 8,
    parameter int COORD_BITS = 16,
    parameter int COLOR_BITS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  t_in_beat                 i_in_data,
    output logic                     o_in_stall,
    output logic                     o_out_valid,
    output t_out_beat                o_out_data,
    input  logic                     i_out_stall,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int CMD_BITS = 2*COORD_BITS + STORE_AW + 9;

    t_cfg                  r_cfg;
    logic [COLOR_BITS-1:0] r_fore_color, r_back_color;
    logic                  q_push, q_full, q_pop, q_valid;
    logic [CMD_BITS-1:0]   q_wdata, q_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_code       <= 8'd32;
            r_cfg.last_code        <= 8'd127;
            r_cfg.cell_width       <= 4'd8;
            r_cfg.scale_factor     <= 4'd1;
            r_cfg.glyph_gap        <= 4'd1;
            r_cfg.paint_background <= 1'b0;
            r_fore_color           <= '1;
            r_back_color           <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_FIRST_CODE:       r_cfg.first_code       <= i_cfg_data[7:0];
                CFG_LAST_CODE:        r_cfg.last_code        <= i_cfg_data[7:0];
                CFG_CELL_WIDTH:       r_cfg.cell_width       <= i_cfg_data[3:0];
                CFG_SCALE_FACTOR:     r_cfg.scale_factor     <= i_cfg_data[3:0];
                CFG_GLYPH_GAP:        r_cfg.glyph_gap        <= i_cfg_data[3:0];
                CFG_PAINT_BACKGROUND: r_cfg.paint_background <= i_cfg_data[0];
                CFG_FORE_COLOR:       r_fore_color           <= COLOR_BITS'(i_cfg_data);
                CFG_BACK_COLOR:       r_back_color           <= COLOR_BITS'(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    bfgr_front #(
        .FONT_SLOTS (FONT_SLOTS),
        .GLYPH_ROWS (GLYPH_ROWS),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_data   (q_wdata)
    );

    bfgr_queue #(
        .WIDTH (CMD_BITS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    bfgr_back #(
        .GLYPH_ROWS (GLYPH_ROWS),
        .COORD_BITS (COORD_BITS),
        .COLOR_BITS (COLOR_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_fore_color (r_fore_color),
        .i_back_color (r_back_color),
        .i_q_valid    (q_valid),
        .i_q_data     (q_rdata),
        .o_q_pop      (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_data   (o_out_data)
    );

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the bitmap font glyph renderer.
`timescale 1ns / 1ps

module tb;
    import bfgr_pkg::*;

    localparam int FONT_SLOTS   = 128;
    localparam int GLYPH_ROWS   = 8;
    localparam int DRAIN_CYCLES = 500;
    localparam int IDLE_GUARD   = 1000000;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    t_in_beat                 i_in_data = '0;
    logic                     o_in_stall;
    logic                     o_out_valid;
    t_out_beat                o_out_data;
    logic                     i_out_stall = 1'b0;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;

    bitmap_font_glyph_renderer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Renderer state and register copies
    logic [7:0]  cf_first = 8'd32;
    logic [7:0]  cf_last = 8'd127;
    logic [3:0]  cf_width = 4'd8;
    logic [3:0]  cf_scale = 4'd1;
    logic [3:0]  cf_gap = 4'd1;
    logic        cf_bg = 1'b0;
    logic [31:0] cf_fore = 32'hFFFF_FFFF;
    logic [31:0] cf_back = 32'h0;
    logic [15:0] pen_x = '0;
    logic [15:0] pen_y = '0;
    logic [15:0] line_x = '0;
    logic [7:0]  glyph_rows [0:STORE_DEPTH-1];

    t_out_beat cell_expect [$];
    t_in_beat  beat_queue [$];
    bit        font_ready [0:STORE_DEPTH-1];
    int        beats_queued = 0;
    int        beats_taken = 0;
    int        err_count = 0;
    bit        in_beat_taken = 1'b0;
    int        burst_left = 0;
    int        gap_left = 0;
    int        stall_run = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit glyph_present(logic [7:0] code);
        return code >= cf_first && code <= cf_last &&
            (int'(code) - int'(cf_first)) < FONT_SLOTS;
    endfunction

    task automatic render_glyph(input logic [7:0] code);
        int w, slot, total, k;
        logic [7:0] bits;
        t_out_beat c;
        w = (cf_width > MAX_WIDTH) ? 8 : int'(cf_width);
        slot = int'(code) - int'(cf_first);
        total = 0;
        for (int pass = 0; pass < 2; pass++) begin
            k = 0;
            for (int gy = 0; gy < GLYPH_ROWS; gy++) begin
                bits = glyph_rows[(slot * GLYPH_ROWS + gy) % STORE_DEPTH];
                for (int gx = 0; gx < w; gx++) begin
                    if (bits[w - 1 - gx] || cf_bg) begin
                        k++;
                        if (pass == 1) begin
                            c.cell_x = pen_x + 16'(gx * cf_scale);
                            c.cell_y = pen_y + 16'(gy * cf_scale);
                            c.cell_color = bits[w - 1 - gx] ? cf_fore : cf_back;
                            c.last_cell = (k == total);
                            cell_expect.push_back(c);
                        end
                    end
                end
            end
            total = k;
        end
        pen_x = pen_x + 16'((w + cf_gap) * cf_scale);
    endtask

    task automatic predict_cells(input t_in_beat b);
        case (t_req'(b.req_type))
            REQ_TEXT: begin
                if (cf_scale != 0) begin
                    if (b.text_start)
                        line_x = pen_x;
                    if (b.char_code == NEWLINE_CODE) begin
                        pen_x = line_x;
                        pen_y = pen_y + 16'((GLYPH_ROWS + cf_gap) * cf_scale);
                    end else if (glyph_present(b.char_code)) begin
                        render_glyph(b.char_code);
                    end
                end
            end
            REQ_GLYPH: begin
                if (cf_scale != 0 && glyph_present(b.char_code)) begin
                    pen_x = b.pos_x;
                    pen_y = b.pos_y;
                    render_glyph(b.char_code);
                end
            end
            REQ_CURSOR: begin
                pen_x = b.pos_x;
                pen_y = b.pos_y;
            end
            default: begin
                glyph_rows[b.font_address] = b.font_row;
            end
        endcase
    endtask

    task automatic apply_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        case (t_cfg_idx'(idx))
            CFG_FIRST_CODE:       cf_first = data[7:0];
            CFG_LAST_CODE:        cf_last = data[7:0];
            CFG_CELL_WIDTH:       cf_width = data[3:0];
            CFG_SCALE_FACTOR:     cf_scale = data[3:0];
            CFG_GLYPH_GAP:        cf_gap = data[3:0];
            CFG_PAINT_BACKGROUND: cf_bg = data[0];
            CFG_FORE_COLOR:       cf_fore = data;
            default:              cf_back = data;
        endcase
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            err_count++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_out_beat want;
        in_beat_taken = i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (cell_expect.size() == 0) begin
                err_count++;
                $display("%0t: unexpected cell, expected none, got %h", $time, o_out_data);
            end else begin
                want = cell_expect.pop_front();
                check_field("cell_x", want.cell_x, o_out_data.cell_x);
                check_field("cell_y", want.cell_y, o_out_data.cell_y);
                check_field("cell_color", want.cell_color, o_out_data.cell_color);
                check_field("last_cell", want.last_cell, o_out_data.last_cell);
            end
        end
        if (i_rst_n && i_cfg_valid && o_cfg_ready)
            apply_reg(i_cfg_index, i_cfg_data);
        if (in_beat_taken) begin
            predict_cells(i_in_data);
            beats_taken++;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_beat_taken)) begin
            if (gap_left > 0 || beat_queue.size() == 0) begin
                if (gap_left > 0)
                    gap_left--;
                i_in_valid <= 1'b0;
            end else begin
                i_in_data <= beat_queue.pop_front();
                i_in_valid <= 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 16);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (stall_run == 0) begin
            if (!i_out_stall)
                stall_run = $urandom_range(1, 8);
            else if ($urandom_range(0, 5) == 0)
                stall_run = $urandom_range(20, 80);
            else
                stall_run = $urandom_range(1, 6);
            i_out_stall <= !i_out_stall;
        end else begin
            stall_run--;
        end
    end

    function automatic t_in_beat noise_beat();
        logic [63:0] r;
        t_in_beat b;
        r = {$urandom, $urandom};
        b = r[$bits(t_in_beat)-1:0];
        return b;
    endfunction

    function automatic t_in_beat make_beat(t_req kind, logic [7:0] code, logic start,
                                           logic [15:0] x, logic [15:0] y,
                                           logic [9:0] addr, logic [7:0] row);
        t_in_beat b;
        b.req_type = kind;
        b.char_code = code;
        b.text_start = start;
        b.pos_x = x;
        b.pos_y = y;
        b.font_address = addr;
        b.font_row = row;
        return b;
    endfunction

    task automatic load_glyph(input logic [7:0] code);
        t_in_beat b;
        int addr;
        bit blank;
        blank = ($urandom_range(0, 7) == 0);
        for (int r = 0; r < GLYPH_ROWS; r++) begin
            addr = ((int'(code) - int'(cf_first)) * GLYPH_ROWS + r) % STORE_DEPTH;
            if (!font_ready[addr]) begin
                b = noise_beat();
                b.req_type = REQ_FONT;
                b.font_address = addr[9:0];
                b.font_row = blank ? 8'h00 : 8'($urandom);
                queue_beat(b);
            end
        end
    endtask

    // Load any glyph rows a draw would read before the draw itself
    task automatic queue_beat(input t_in_beat b);
        if (cf_scale != 0 && glyph_present(b.char_code) &&
            (b.req_type == REQ_GLYPH ||
             (b.req_type == REQ_TEXT && b.char_code != NEWLINE_CODE)))
            load_glyph(b.char_code);
        if (b.req_type == REQ_FONT)
            font_ready[b.font_address] = 1'b1;
        beat_queue.push_back(b);
        beats_queued++;
    endtask

    function automatic logic [7:0] pick_code();
        int top, near;
        top = int'(cf_last);
        if (top > int'(cf_first) + FONT_SLOTS - 1)
            top = int'(cf_first) + FONT_SLOTS - 1;
        near = (top > int'(cf_first) + 11) ? int'(cf_first) + 11 : top;
        if (cf_first > cf_last)
            return 8'($urandom);
        case ($urandom_range(0, 9))
            0:       return NEWLINE_CODE;
            1:       return 8'($urandom);
            2, 3:    return 8'($urandom_range(top, int'(cf_first)));
            default: return 8'($urandom_range(near, int'(cf_first)));
        endcase
    endfunction

    task automatic queue_random(input int count);
        t_in_beat b;
        int k;
        repeat (count) begin
            b = noise_beat();
            k = $urandom_range(0, 99);
            if (k < 45) begin
                b.req_type = REQ_TEXT;
                b.char_code = pick_code();
                b.text_start = ($urandom_range(0, 5) == 0);
            end else if (k < 65) begin
                b.req_type = REQ_GLYPH;
                b.char_code = pick_code();
            end else if (k < 75) begin
                b.req_type = REQ_CURSOR;
            end else if (k < 85) begin
                b.req_type = REQ_FONT;
            end
            queue_beat(b);
        end
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_BITS-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [7:0] first, input logic [7:0] last,
                              input logic [3:0] width, input logic [3:0] scale,
                              input logic [3:0] gap, input logic bg,
                              input logic [31:0] fore, input logic [31:0] back);
        write_reg(CFG_FIRST_CODE, 32'(first));
        write_reg(CFG_LAST_CODE, 32'(last));
        write_reg(CFG_CELL_WIDTH, 32'(width));
        write_reg(CFG_SCALE_FACTOR, 32'(scale));
        write_reg(CFG_GLYPH_GAP, 32'(gap));
        write_reg(CFG_PAINT_BACKGROUND, 32'(bg));
        write_reg(CFG_FORE_COLOR, fore);
        write_reg(CFG_BACK_COLOR, back);
    endtask

    task automatic random_config();
        logic [7:0] lo, hi;
        lo = 8'($urandom);
        hi = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(255, lo));
        set_config(lo, hi, 4'($urandom), 4'($urandom_range(15, 1)), 4'($urandom),
                   1'($urandom), $urandom, $urandom);
    endtask

    task automatic drain_block();
        int guard;
        guard = 0;
        while ((beats_taken != beats_queued || cell_expect.size() != 0) &&
               guard < IDLE_GUARD) begin
            @(posedge i_clk);
            guard++;
        end
        if (beats_taken != beats_queued) begin
            err_count++;
            $display("%0t: input stuck, expected %0d beats taken, got %0d",
                     $time, beats_queued, beats_taken);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_directed();
        logic [7:0] rows [0:7];
        rows = '{8'hFF, 8'h00, 8'h80, 8'h01, 8'hAA, 8'h55, 8'h3C, 8'hC3};
        for (int r = 0; r < GLYPH_ROWS; r++)
            queue_beat(make_beat(REQ_FONT, 8'h0, 1'b0, 16'h0, 16'h0, 10'(264 + r), rows[r]));
        queue_beat(make_beat(REQ_CURSOR, 8'h0, 1'b0, 16'hFFF8, 16'hFFFC, 10'h0, 8'h0));
        queue_beat(make_beat(REQ_TEXT, "A", 1'b1, 16'h0, 16'h0, 10'h0, 8'h0));
        queue_beat(make_beat(REQ_TEXT, "A", 1'b0, 16'h0, 16'h0, 10'h0, 8'h0));
        queue_beat(make_beat(REQ_TEXT, NEWLINE_CODE, 1'b0, 16'h0, 16'h0, 10'h0, 8'h0));
        queue_beat(make_beat(REQ_GLYPH, "A", 1'b0, 16'h0, 16'h0, 10'h0, 8'h0));
        queue_beat(make_beat(REQ_GLYPH, "A", 1'b0, 16'hFFFF, 16'hFFFF, 10'h0, 8'h0));
        queue_beat(make_beat(REQ_TEXT, 8'd31, 1'b0, 16'h0, 16'h0, 10'h0, 8'h0));
        queue_beat(make_beat(REQ_TEXT, 8'd128, 1'b0, 16'h0, 16'h0, 10'h0, 8'h0));
        queue_beat(make_beat(REQ_TEXT, 8'd255, 1'b1, 16'h0, 16'h0, 10'h0, 8'h0));
        queue_beat(make_beat(REQ_GLYPH, NEWLINE_CODE, 1'b0, 16'h1234, 16'h5678, 10'h0, 8'h0));
        queue_beat(make_beat(REQ_GLYPH, 8'd0, 1'b0, 16'h4321, 16'h8765, 10'h0, 8'h0));
        queue_beat(make_beat(REQ_FONT, 8'h0, 1'b0, 16'h0, 16'h0, 10'h3FF, 8'hFF));
        queue_beat(make_beat(REQ_TEXT, "A", 1'b1, 16'h0, 16'h0, 10'h0, 8'h0));
        queue_beat(make_beat(REQ_TEXT, NEWLINE_CODE, 1'b0, 16'h0, 16'h0, 10'h0, 8'h0));
        queue_beat(make_beat(REQ_TEXT, "A", 1'b0, 16'h0, 16'h0, 10'h0, 8'h0));
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_config(8'd32, 8'd127, 4'd8, 4'd1, 4'd1, 1'b0, 32'hFFFF_FFFF, 32'h0);
        queue_directed();
        queue_random(20);
        drain_block();

        set_config(8'd0, 8'd255, 4'd1, 4'd15, 4'd15, 1'b1, $urandom, $urandom);
        queue_random(22);
        drain_block();

        set_config(8'd200, 8'd100, 4'd15, 4'd2, 4'd7, 1'b0, $urandom, $urandom);
        queue_random(12);
        drain_block();

        set_config(8'd64, 8'd200, 4'd15, 4'd3, 4'd0, 1'b1, 32'h0, 32'hFFFF_FFFF);
        queue_random(22);
        drain_block();

        set_config(8'd0, 8'd127, 4'd8, 4'd0, 4'd3, 1'b1, $urandom, $urandom);
        queue_random(15);
        drain_block();

        set_config(8'd0, 8'd20, 4'd0, 4'd4, 4'd2, 1'b1, $urandom, $urandom);
        queue_random(15);
        drain_block();

        repeat (2) begin
            random_config();
            queue_random(22);
            drain_block();
        end

        if (cell_expect.size() != 0) begin
            err_count++;
            $display("%0t: %0d expected cells never arrived, expected none left, got %0d",
                     $time, cell_expect.size(), cell_expect.size());
        end
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #100_000_000;
        $display("%0t: timeout", $time);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
